// File: rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check on one clock with async reset disable.
`define WSD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define WSD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/wsd_pkg.sv
// Package: shared types and codes of the websocket frame deframer.
`timescale 1ns / 1ps
package wsd_pkg;

	// parser phases
	localparam logic [2:0] PH_BYTE0  = 3'd0;
	localparam logic [2:0] PH_BYTE1  = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_KEY    = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_HALT   = 3'd5;

	// result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// error codes
	localparam logic [1:0] ERR_RSV      = 2'd0;
	localparam logic [1:0] ERR_OPCODE   = 2'd1;
	localparam logic [1:0] ERR_UNMASKED = 2'd2;

	// extended length forms
	localparam logic [1:0] LEN_SHORT = 2'd0;
	localparam logic [1:0] LEN_16    = 2'd1;
	localparam logic [1:0] LEN_64    = 2'd2;

	// 7-bit length codes that announce an extended length
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	// one result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] payload_byte;
		logic [3:0] opcode;
		logic       fin;
		logic       frame_end;
		logic       message_end;
		logic [1:0] error_code;
	} res_t;

endpackage

// File: rtl/websocket_frame_deframer_top.sv
// Top level of the websocket frame deframer.
//
// Takes the received byte stream on rx_byte with rx_valid/rx_stall; a byte
// transfers at a clock edge with rx_valid high and rx_stall low. Results leave
// on the kind .. error_code ports with res_valid/res_stall, same rule.
// Frame headers (FIN, RSV, opcode, 7/16/64-bit length, mask key) produce no
// result except the one that closes an empty frame; each payload byte comes
// out unmasked with its frame and message end marks. A protocol error gives
// one error result and all later bytes are dropped until reset.
// Path: a transferred byte is held in the input register, then the parse logic
// writes its result into the result register, which drives res_valid.
// Throughput: one byte per clock unless res_stall holds a result; the parse of
// a byte is a single pass over the header state and the 64-bit length counter.
// Reset (arst_n low) empties both registers, returns the parser to the first
// header byte and sets require_mask to 1. cfg_wr_en/cfg_wr_data write
// require_mask; write it only while no bytes are in flight.
// A stalled result holds its register; the input register keeps one byte and
// then raises rx_stall until the result transfers.
`timescale 1ns / 1ps
module websocket_frame_deframer_top
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [1:0] kind,
	output logic [7:0] payload_byte,
	output logic [3:0] opcode,
	output logic       fin,
	output logic       frame_end,
	output logic       message_end,
	output logic [1:0] error_code
);

	logic       advance;
	logic       byte_valid_s1;
	logic [7:0] byte_s1;
	logic       emit;
	res_t       res;
	res_t       res_q;

	wsd_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.rx_byte       (rx_byte),
		.advance       (advance),
		.byte_valid_s1 (byte_valid_s1),
		.byte_s1       (byte_s1)
	);

	wsd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.byte_valid_s1 (byte_valid_s1),
		.byte_s1       (byte_s1),
		.advance       (advance),
		.emit          (emit),
		.res           (res)
	);

	wsd_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.emit          (emit),
		.byte_valid_s1 (byte_valid_s1),
		.res           (res),
		.advance       (advance),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res_q         (res_q)
	);

	// result fields to ports
	assign kind         = res_q.kind;
	assign payload_byte = res_q.payload_byte;
	assign opcode       = res_q.opcode;
	assign fin          = res_q.fin;
	assign frame_end    = res_q.frame_end;
	assign message_end  = res_q.message_end;
	assign error_code   = res_q.error_code;

endmodule

// File: rtl/wsd_in_stage.sv
// Input register stage of the deframer: holds one received byte.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsd_in_stage
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       byte_valid_s1,
	output logic [7:0] byte_s1
);

	logic take;

	// stall only while a held byte cannot move on
	assign rx_stall = byte_valid_s1 && !advance;
	assign take     = rx_valid && !rx_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (!byte_valid_s1 || advance) begin
			byte_valid_s1 <= rx_valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx_byte;
		end
	end

	`WSD_ASSERT_NEXT(a_hold_s1, clk, arst_n, byte_valid_s1 && !advance,
		byte_valid_s1 && $stable(byte_s1), "held input byte lost or changed")

endmodule

// File: rtl/wsd_parser.sv
// Frame parser: header state, length and key registers, unmasking logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsd_parser
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       byte_valid_s1,
	input  logic [7:0] byte_s1,
	input  logic       advance,
	output logic       emit,
	output res_t       res
);

	logic        require_mask_q;
	logic [2:0]  phase_q,  phase_d;
	logic [3:0]  hc_q,     hc_d;
	logic        fin_q,    fin_d;
	logic [3:0]  op_q,     op_d;
	logic [1:0]  lk_q,     lk_d;
	logic        masked_q, masked_d;
	logic [63:0] rem_q,    rem_d;
	logic [31:0] key_q,    key_d;
	logic [1:0]  idx_q,    idx_d;

	logic        fire;
	logic [3:0]  hc_inc;
	logic [63:0] rem_shift;
	logic [7:0]  key_byte;
	logic        ext_done;
	logic [1:0]  kind_d;
	logic [7:0]  pbyte_d;
	logic        fend_d;
	logic [1:0]  code_d;

	assign fire      = byte_valid_s1 && advance;
	assign hc_inc    = hc_q + 4'd1;
	assign rem_shift = {rem_q[55:0], byte_s1};
	assign ext_done  = (lk_q == LEN_16) ? (hc_inc >= 4'd2) : (hc_inc >= 4'd8);

	// key byte for this payload position, first key byte in the top bits
	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state and result for the byte in s1
	always_comb begin
		phase_d  = phase_q;
		hc_d     = hc_q;
		fin_d    = fin_q;
		op_d     = op_q;
		lk_d     = lk_q;
		masked_d = masked_q;
		rem_d    = rem_q;
		key_d    = key_q;
		idx_d    = idx_q;
		emit     = 1'b0;
		kind_d   = KIND_DATA;
		pbyte_d  = 8'd0;
		fend_d   = 1'b0;
		code_d   = ERR_RSV;
		case (phase_q)
			PH_BYTE0: begin
				fin_d = byte_s1[7];
				op_d  = byte_s1[3:0];
				key_d = 32'd0;
				idx_d = 2'd0;
				hc_d  = 4'd0;
				if (byte_s1[6:4] != 3'd0) begin
					phase_d = PH_HALT;
					emit    = 1'b1;
					kind_d  = KIND_ERROR;
					code_d  = ERR_RSV;
				end else if (byte_s1[3:0] inside {[4'd3:4'd7], [4'd11:4'd15]}) begin
					phase_d = PH_HALT;
					emit    = 1'b1;
					kind_d  = KIND_ERROR;
					code_d  = ERR_OPCODE;
				end else begin
					phase_d = PH_BYTE1;
				end
			end
			PH_BYTE1: begin
				masked_d = byte_s1[7];
				hc_d     = 4'd0;
				if (!byte_s1[7] && require_mask_q) begin
					phase_d = PH_HALT;
					emit    = 1'b1;
					kind_d  = KIND_ERROR;
					code_d  = ERR_UNMASKED;
				end else if (byte_s1[6:0] == LEN7_EXT16) begin
					rem_d   = 64'd0;
					lk_d    = LEN_16;
					phase_d = PH_EXTLEN;
				end else if (byte_s1[6:0] == LEN7_EXT64) begin
					rem_d   = 64'd0;
					lk_d    = LEN_64;
					phase_d = PH_EXTLEN;
				end else begin
					lk_d  = LEN_SHORT;
					rem_d = {57'd0, byte_s1[6:0]};
					// length known: key, payload or empty frame
					if (byte_s1[7]) begin
						phase_d = PH_KEY;
					end else if (byte_s1[6:0] == 7'd0) begin
						phase_d = PH_BYTE0;
						emit    = 1'b1;
						kind_d  = KIND_EMPTY;
						fend_d  = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_EXTLEN: begin
				rem_d = rem_shift;
				hc_d  = hc_inc;
				if (ext_done) begin
					hc_d = 4'd0;
					if (masked_q) begin
						phase_d = PH_KEY;
					end else if (rem_shift == 64'd0) begin
						phase_d = PH_BYTE0;
						emit    = 1'b1;
						kind_d  = KIND_EMPTY;
						fend_d  = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], byte_s1};
				hc_d  = hc_inc;
				if (hc_inc >= 4'd4) begin
					hc_d  = 4'd0;
					idx_d = 2'd0;
					if (rem_q == 64'd0) begin
						phase_d = PH_BYTE0;
						emit    = 1'b1;
						kind_d  = KIND_EMPTY;
						fend_d  = 1'b1;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				idx_d   = idx_q + 2'd1;
				rem_d   = rem_q - 64'd1;
				emit    = 1'b1;
				kind_d  = KIND_DATA;
				pbyte_d = byte_s1 ^ key_byte;
				fend_d  = (rem_q == 64'd1);
				if (rem_q == 64'd1) begin
					phase_d = PH_BYTE0;
				end
			end
			default: begin
				// halted after an error: bytes are dropped
				phase_d = phase_q;
			end
		endcase
	end

	// result fields use the frame header as updated by this byte
	assign res.kind         = kind_d;
	assign res.payload_byte = pbyte_d;
	assign res.opcode       = op_d;
	assign res.fin          = fin_d;
	assign res.frame_end    = fend_d;
	assign res.message_end  = fend_d & fin_d;
	assign res.error_code   = code_d;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			require_mask_q <= 1'b1;
		end else if (cfg_wr_en) begin
			require_mask_q <= cfg_wr_data;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BYTE0;
			hc_q     <= 4'd0;
			fin_q    <= 1'b0;
			op_q     <= 4'd0;
			lk_q     <= LEN_SHORT;
			masked_q <= 1'b0;
			rem_q    <= 64'd0;
			key_q    <= 32'd0;
			idx_q    <= 2'd0;
		end else if (fire) begin
			phase_q  <= phase_d;
			hc_q     <= hc_d;
			fin_q    <= fin_d;
			op_q     <= op_d;
			lk_q     <= lk_d;
			masked_q <= masked_d;
			rem_q    <= rem_d;
			key_q    <= key_d;
			idx_q    <= idx_d;
		end
	end

	`WSD_ASSERT_NEXT(a_halt_sticky, clk, arst_n, phase_q == PH_HALT,
		phase_q == PH_HALT, "parser left halt without reset")
	`WSD_ASSERT_NEXT(a_err_halts, clk, arst_n, fire && emit && (kind_d == KIND_ERROR),
		phase_q == PH_HALT, "error transfer without halt")

endmodule

// File: rtl/wsd_out_stage.sv
// Result register of the deframer with its valid/stall handshake.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wsd_out_stage
	import wsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       emit,
	input  logic       byte_valid_s1,
	input  res_t       res,
	output logic       advance,
	output logic       res_valid,
	input  logic       res_stall,
	output res_t       res_q
);

	logic load;

	// the register frees up when empty or when its result transfers now
	assign advance = !res_valid || !res_stall;
	assign load    = advance && byte_valid_s1 && emit;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= byte_valid_s1 && emit;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	`WSD_ASSERT(a_msg_end, clk, arst_n,
		!res_valid || !res_q.message_end || (res_q.frame_end && res_q.fin),
		"message end without frame end and fin")
	`WSD_ASSERT(a_err_fields, clk, arst_n,
		!res_valid || (res_q.kind == KIND_ERROR) || (res_q.error_code == ERR_RSV),
		"error code set on a non-error result")

endmodule
